// ===== rtl/assert_macros.svh =====
// Assertion macros used by the trig function unit RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== rtl/tfu_pkg.sv =====
// Types and constants of the trig function unit
package tfu_pkg;
	typedef enum logic [2:0] {
		ACT_SIN = 3'd0, ACT_COS = 3'd1, ACT_TAN = 3'd2,
		ACT_COT = 3'd3, ACT_SEC = 3'd4, ACT_CSC = 3'd5
	} action_t;
	typedef struct packed {
		logic [2:0]         action;
		logic signed [31:0] angle;
	} in_t;
	typedef struct packed {
		logic signed [47:0] value;
		logic               status;
	} out_t;
	localparam logic [35:0] Q_ONE        = 36'd4294967296;
	localparam logic [35:0] Q_TWO_PI     = 36'd26986075409;
	localparam logic [35:0] Q_PI         = 36'd13493037705;
	localparam logic [35:0] Q_HALF_PI    = 36'd6746518852;
	localparam logic [35:0] Q_QUARTER_PI = 36'd3373259426;
	localparam logic [48:0] MAG_LIMIT    = 49'd140737488355328;
	localparam logic [31:0] POLE_RESET   = 32'd4295;
endpackage

// ===== rtl/trig_function_unit.sv =====
// Top level of the pipelined trig function unit
//  channel | signals                 | handshake
//  in      | start, busy, in_item    | taken when start && !busy
//  config  | cfg_we, cfg_data        | written when cfg_we
//  out     | done, out_item          | one-cycle strobe, no stall
// One transaction enters per cycle; busy is always low.
// The pipeline holds RED+1 reduction registers, fold, 2*SER+1 series registers (two per
// Horner term, the tail passes through), operand select, DIV+1 restoring divider registers
// and the output register.
// Reset clears the valid bits and loads the pole threshold; the receiver cannot stall.
`include "assert_macros.svh"
module trig_function_unit #(
	parameter int SERIES_TERMS    = 10,
	parameter int ANGLE_FRAC_BITS = 24,
	parameter int OUT_FRAC_BITS   = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  tfu_pkg::in_t   in_item,
	input  logic           cfg_we,
	input  logic [31:0]    cfg_data,
	output logic           done,
	output tfu_pkg::out_t  out_item
);
	localparam int RED = 38;              // reduction steps, 2^37*2pi > 2^48
	localparam int SER = 2 * SERIES_TERMS + 3;
	// quotient bits: integer part, OUT_FRAC_BITS fraction bits and one round bit
	localparam int DIV = 49;
	localparam int IB  = DIV - OUT_FRAC_BITS - 1;
	localparam int LAT = RED + 2 * SER + DIV + 6;

	logic [31:0] thr_q;

	// hold the pole threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= tfu_pkg::POLE_RESET;
		else if (cfg_we) thr_q <= cfg_data;
	end

	assign busy = 1'b0;

	// valid chain through all stages
	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[LAT-2:0], start};
	end

	// ---------------- range reduction: restoring remainder ----------------
	typedef struct packed {
		logic [2:0]  act;
		logic        neg;
		logic [47:0] rem;
	} red_t;
	red_t red_s1 [RED+1];
	always_ff @(posedge clk) begin
		red_s1[0].act <= in_item.action;
		red_s1[0].neg <= in_item.angle[31];
		red_s1[0].rem <= 48'(in_item.angle[31] ? 33'(-$signed({in_item.angle[31],
			in_item.angle})) : 33'({1'b0, in_item.angle})) << (32 - ANGLE_FRAC_BITS);
	end
	for (genvar k = 0; k < RED; k++) begin : g_red
		localparam logic [76:0] M = 77'(tfu_pkg::Q_TWO_PI) << (RED - 1 - k);
		always_ff @(posedge clk) begin
			red_t nx;
			nx = red_s1[k];
			if (77'(red_s1[k].rem) >= M) nx.rem = 48'(77'(red_s1[k].rem) - M);
			red_s1[k+1] <= nx;
		end
	end

	// ---------------- fold into [0, pi/2] ----------------
	typedef struct packed {
		logic [2:0]  act;
		logic        sneg;
		logic        cneg;
		logic        swap;
		logic [35:0] z;
	} fold_t;
	fold_t fold_s2;
	always_ff @(posedge clk) begin
		logic [35:0] r, y;
		r = 36'(red_s1[RED].rem);
		if (red_s1[RED].neg && r != 0) r = tfu_pkg::Q_TWO_PI - r;
		fold_s2.act <= red_s1[RED].act;
		if (r < tfu_pkg::Q_HALF_PI) begin
			y = r; fold_s2.sneg <= 1'b0; fold_s2.cneg <= 1'b0;
		end else if (r < tfu_pkg::Q_PI) begin
			y = tfu_pkg::Q_PI - r; fold_s2.sneg <= 1'b0; fold_s2.cneg <= 1'b1;
		end else if (r < tfu_pkg::Q_PI + tfu_pkg::Q_HALF_PI) begin
			y = r - tfu_pkg::Q_PI; fold_s2.sneg <= 1'b1; fold_s2.cneg <= 1'b1;
		end else begin
			y = tfu_pkg::Q_TWO_PI - r; fold_s2.sneg <= 1'b1; fold_s2.cneg <= 1'b0;
		end
		if (y > tfu_pkg::Q_HALF_PI) y = tfu_pkg::Q_HALF_PI;
		fold_s2.swap <= (y > tfu_pkg::Q_QUARTER_PI);
		fold_s2.z <= (y > tfu_pkg::Q_QUARTER_PI) ? tfu_pkg::Q_HALF_PI - y : y;
	end

	// ---------------- Horner series, two stages per term ----------------
	typedef struct packed {
		logic [2:0]  act;
		logic        sneg;
		logic        cneg;
		logic        swap;
		logic [35:0] z;
		logic [35:0] z2;
		logic [35:0] s;
		logic [35:0] c;
		logic [35:0] ps;
		logic [35:0] pc;
	} ser_t;
	ser_t ser_s3 [2*SER+1];
	always_ff @(posedge clk) begin
		ser_s3[0].act  <= fold_s2.act;
		ser_s3[0].sneg <= fold_s2.sneg;
		ser_s3[0].cneg <= fold_s2.cneg;
		ser_s3[0].swap <= fold_s2.swap;
		ser_s3[0].z    <= fold_s2.z;
		ser_s3[0].z2   <= 36'((72'(fold_s2.z) * 72'(fold_s2.z) + 72'h80000000) >> 32);
		ser_s3[0].s    <= tfu_pkg::Q_ONE;
		ser_s3[0].c    <= tfu_pkg::Q_ONE;
		ser_s3[0].ps   <= '0;
		ser_s3[0].pc   <= '0;
	end
	// stage pair per term: product, then rounded division by constant
	// done as an exact reciprocal multiplication (dividend below 2^33)
	for (genvar t = 0; t < SER; t++) begin : g_ser
		localparam int I = SERIES_TERMS - t;
		localparam logic [35:0] DS = (I > 0) ? 36'(2 * I * (2 * I + 1)) : 36'd1;
		localparam logic [35:0] DC = (I > 0) ? 36'(2 * I * (2 * I - 1)) : 36'd1;
		localparam int KS = 33 + $clog2(DS);
		localparam int KC = 33 + $clog2(DC);
		localparam logic [35:0] MS = 36'(((72'd1 << KS) + 72'(DS) - 72'd1) / 72'(DS));
		localparam logic [35:0] MC = 36'(((72'd1 << KC) + 72'(DC) - 72'd1) / 72'(DC));
		always_ff @(posedge clk) begin
			ser_t nx;
			nx = ser_s3[2*t];
			if (I > 0) begin
				nx.ps = 36'((72'(ser_s3[2*t].z2) * 72'(ser_s3[2*t].s)
					+ 72'h80000000) >> 32);
				nx.pc = 36'((72'(ser_s3[2*t].z2) * 72'(ser_s3[2*t].c)
					+ 72'h80000000) >> 32);
			end else if (I == 0) begin
				nx.ps = 36'((72'(ser_s3[2*t].z) * 72'(ser_s3[2*t].s)
					+ 72'h80000000) >> 32);
			end
			ser_s3[2*t+1] <= nx;
		end
		always_ff @(posedge clk) begin
			ser_t nx;
			nx = ser_s3[2*t+1];
			if (I > 0) begin
				nx.s = tfu_pkg::Q_ONE - 36'(((72'(ser_s3[2*t+1].ps) + 72'(DS / 2))
					* 72'(MS)) >> KS);
				nx.c = tfu_pkg::Q_ONE - 36'(((72'(ser_s3[2*t+1].pc) + 72'(DC / 2))
					* 72'(MC)) >> KC);
			end else if (I == 0) begin
				nx.s = ser_s3[2*t+1].ps;
			end
			ser_s3[2*t+2] <= nx;
		end
	end

	// ---------------- operand select and pole check ----------------
	typedef struct packed {
		logic        act_ok;
		logic        trig;
		logic        pole;
		logic        qneg;
		logic [35:0] mag;
		logic [35:0] den;
	} sel_t;
	sel_t sel_s4;
	always_ff @(posedge clk) begin
		logic [35:0] sm, cm, dm, nm;
		logic        dneg, nneg, oc;
		tfu_pkg::action_t a;
		ser_t e;
		e  = ser_s3[2*SER];
		a  = tfu_pkg::action_t'(e.act);
		sm = e.swap ? e.c : e.s;
		cm = e.swap ? e.s : e.c;
		oc = (a == tfu_pkg::ACT_TAN) || (a == tfu_pkg::ACT_SEC);
		dm = oc ? cm : sm;
		dneg = oc ? e.cneg : e.sneg;
		nm = tfu_pkg::Q_ONE; nneg = 1'b0;
		if (a == tfu_pkg::ACT_TAN) begin nm = sm; nneg = e.sneg; end
		if (a == tfu_pkg::ACT_COT) begin nm = cm; nneg = e.cneg; end
		sel_s4.act_ok <= (e.act <= tfu_pkg::ACT_CSC);
		sel_s4.trig   <= (e.act <= tfu_pkg::ACT_COS);
		sel_s4.pole   <= (dneg && dm != 0) ? (dm < 36'(thr_q)) : (dm <= 36'(thr_q));
		sel_s4.qneg   <= (a == tfu_pkg::ACT_SIN) ? e.sneg :
			(a == tfu_pkg::ACT_COS) ? e.cneg : (nneg != dneg);
		sel_s4.mag    <= (a == tfu_pkg::ACT_SIN) ? sm : (a == tfu_pkg::ACT_COS) ? cm : nm;
		sel_s4.den    <= (dm == 0) ? 36'd1 : dm;
	end

	// ---------------- restoring divider, one bit per stage ----------------
	typedef struct packed {
		logic        act_ok;
		logic        trig;
		logic        pole;
		logic        qneg;
		logic        ovf;
		logic [35:0] den;
		logic [36:0] rem;
		logic [DIV-1:0] quo;
		logic [35:0] num;
	} div_t;
	div_t div_s5 [DIV+1];
	// start from the numerator bits above the integer quotient window; flag overflow
	always_ff @(posedge clk) begin
		div_s5[0].act_ok <= sel_s4.act_ok;
		div_s5[0].trig   <= sel_s4.trig;
		div_s5[0].pole   <= sel_s4.pole;
		div_s5[0].qneg   <= sel_s4.qneg;
		div_s5[0].ovf    <= (sel_s4.mag >> IB) >= sel_s4.den;
		div_s5[0].den    <= sel_s4.den;
		div_s5[0].rem    <= 37'(sel_s4.mag >> IB);
		div_s5[0].quo    <= '0;
		div_s5[0].num    <= sel_s4.mag;
	end
	// numerator bits IB-1..0 followed by OUT_FRAC_BITS zeros, and one round bit
	for (genvar k = 0; k < DIV; k++) begin : g_div
		localparam int NB = IB - 1 - k;
		always_ff @(posedge clk) begin
			logic [37:0] sh;
			div_t nx;
			nx = div_s5[k];
			sh = {div_s5[k].rem, ((NB >= 0) ? div_s5[k].num[(NB >= 0) ? NB : 0] : 1'b0)};
			if (sh >= 38'(div_s5[k].den)) begin
				nx.rem = 37'(sh - 38'(div_s5[k].den));
				nx.quo = {div_s5[k].quo[DIV-2:0], 1'b1};
			end else begin
				nx.rem = 37'(sh);
				nx.quo = {div_s5[k].quo[DIV-2:0], 1'b0};
			end
			div_s5[k+1] <= nx;
		end
	end

	// ---------------- round, saturate, pack ----------------
	typedef struct packed {
		logic        v;
		logic        neg;
		logic        zero;
		logic        stat;
		logic [DIV+1:0] mag;
	} fin_t;
	fin_t fin_s6;
	always_ff @(posedge clk) begin
		div_t e;
		logic [DIV+1:0] m;
		logic [DIV+1:0] q;
		e = div_s5[DIV];
		q = (DIV+2)'(e.quo[DIV-1:1]) + (DIV+2)'(e.quo[0]);
		// integer part of quotient limit check
		if (e.ovf || (e.quo[DIV-1:OUT_FRAC_BITS+1]) >= (DIV-1-OUT_FRAC_BITS)'(
				tfu_pkg::MAG_LIMIT >> OUT_FRAC_BITS))
			q = (DIV+2)'(tfu_pkg::MAG_LIMIT);
		if (OUT_FRAC_BITS >= 32)
			m = (DIV+2)'(e.num) << (OUT_FRAC_BITS - 32);
		else
			m = ((DIV+2)'(e.num) + ((DIV+2)'(1) << (31 - OUT_FRAC_BITS)))
				>> (32 - OUT_FRAC_BITS);
		fin_s6.mag  <= e.trig ? m : q;
		fin_s6.neg  <= e.qneg;
		fin_s6.zero <= !e.act_ok || (!e.trig && e.pole);
		fin_s6.stat <= e.act_ok && !e.trig && e.pole;
		fin_s6.v    <= 1'b1;
	end

	// drive the result
	always_comb begin
		logic [DIV+1:0] m;
		m = fin_s6.mag;
		if (fin_s6.neg) begin
			if (m > (DIV+2)'(tfu_pkg::MAG_LIMIT)) m = (DIV+2)'(tfu_pkg::MAG_LIMIT);
			out_item.value = 48'(-m);
		end else begin
			if (m > (DIV+2)'(tfu_pkg::MAG_LIMIT - 1)) m = (DIV+2)'(tfu_pkg::MAG_LIMIT - 1);
			out_item.value = 48'(m);
		end
		if (fin_s6.zero) out_item.value = '0;
		out_item.status = fin_s6.stat;
	end
	assign done = vld_q[LAT-1] && fin_s6.v;

	`ASSERT_IMPLIES(a_busy_low, clk, arst_n, 1'b1, !busy)
	`ASSERT_IMPLIES(a_pole_zero, clk, arst_n, done && out_item.status, out_item.value == 0)
	`ASSERT_NEXT(a_pipe_adv, clk, arst_n, vld_q[0], vld_q[1])
endmodule

// ===== tb/sv/tb_trig_function_unit.sv =====
// Self-checking testbench for the trig function unit: bit-exact predictor and scoreboard
`timescale 1ns / 100ps
module tb_trig_function_unit;
	typedef bit [63:0] u64_t;

	localparam int   TERMS       = 10;
	localparam int   ANG_FRAC    = 24;
	localparam u64_t ONE_Q       = 64'd4294967296;
	localparam u64_t TWO_PI_Q    = 64'd26986075409;
	localparam u64_t PI_Q        = 64'd13493037705;
	localparam u64_t HALF_PI_Q   = 64'd6746518852;
	localparam u64_t QTR_PI_Q    = 64'd3373259426;
	localparam u64_t HALF_Q      = 64'd2147483648;
	localparam u64_t SAT_LIMIT   = 64'd140737488355328;
	// unused action codes
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;
	// angles in Q8.24
	localparam logic [31:0] ANG_QTR_PI  = 32'd13176795;
	localparam logic [31:0] ANG_HALF_PI = 32'd26353589;
	localparam logic [31:0] ANG_PI      = 32'd52707179;
	localparam logic [31:0] ANG_TWO_PI  = 32'd105414357;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	tfu_pkg::in_t   in_item = '0;
	logic  cfg_we = 1'b0;
	logic  [31:0] cfg_data = '0;
	logic  done;
	tfu_pkg::out_t  out_item;

	tfu_pkg::out_t  expected_q[$];
	u64_t  pole_limit = 64'd4295;
	int    error_count = 0;
	bit    no_gaps = 1'b0;

	trig_function_unit uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .in_item(in_item),
		.cfg_we(cfg_we), .cfg_data(cfg_data), .done(done), .out_item(out_item)
	);

	always #1 clk = ~clk;

	// Rounded fixed-point product and rounded division by a series constant
	function automatic u64_t qmul(u64_t a, u64_t b);
		return (a * b + HALF_Q) >> 32;
	endfunction

	function automatic u64_t rdiv(u64_t a, u64_t d);
		return (a + d / 2) / d;
	endfunction

	// Horner Taylor series; odd selects sine, even cosine
	function automatic u64_t taylor(u64_t z, bit odd);
		u64_t z2;
		u64_t acc;
		u64_t k;
		z2 = qmul(z, z);
		acc = ONE_Q;
		for (k = TERMS; k > 0; k--)
			acc = ONE_Q - rdiv(qmul(z2, acc), odd ? 2*k*(2*k+1) : 2*k*(2*k-1));
		return odd ? qmul(z, acc) : acc;
	endfunction

	function automatic logic [47:0] saturate(u64_t mag, bit neg);
		u64_t m;
		m = mag;
		if (neg) begin
			if (m > SAT_LIMIT) m = SAT_LIMIT;
			m = 64'd0 - m;
		end else if (m > SAT_LIMIT - 1) begin
			m = SAT_LIMIT - 1;
		end
		return m[47:0];
	endfunction

	// Long division to 32 fraction bits, rounded half up, saturating a large integer part
	function automatic u64_t divide_q(u64_t n, u64_t d);
		u64_t q;
		u64_t r;
		q = n / d;
		r = n % d;
		if (q >= (SAT_LIMIT >> 32)) return SAT_LIMIT;
		for (int k = 0; k < 32; k++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r -= d;
				q |= 1;
			end
		end
		r = r << 1;
		if (r >= d) q++;
		return q;
	endfunction

	function automatic tfu_pkg::out_t trig_predict(logic [2:0] act, logic [31:0] ang);
		tfu_pkg::out_t res;
		u64_t amag, r, y, z, sm, cm, dm, nm;
		bit   sneg, cneg, dneg, nneg, pole;
		amag = ang[31] ? 64'h1_0000_0000 - u64_t'(ang) : u64_t'(ang);
		r = (amag << (32 - ANG_FRAC)) % TWO_PI_Q;
		if (ang[31] && r != 0) r = TWO_PI_Q - r;
		// fold into the first quadrant
		if (r < HALF_PI_Q) begin
			y = r; sneg = 0; cneg = 0;
		end else if (r < PI_Q) begin
			y = PI_Q - r; sneg = 0; cneg = 1;
		end else if (r < PI_Q + HALF_PI_Q) begin
			y = r - PI_Q; sneg = 1; cneg = 1;
		end else begin
			y = TWO_PI_Q - r; sneg = 1; cneg = 0;
		end
		if (y > HALF_PI_Q) y = HALF_PI_Q;
		// above pi/4 swap to the complementary angle
		if (y > QTR_PI_Q) begin
			z = HALF_PI_Q - y;
			sm = taylor(z, 0);
			cm = taylor(z, 1);
		end else begin
			sm = taylor(y, 1);
			cm = taylor(y, 0);
		end
		res = '0;
		case (act)
			tfu_pkg::ACT_SIN: res.value = saturate(sm, sneg);
			tfu_pkg::ACT_COS: res.value = saturate(cm, cneg);
			tfu_pkg::ACT_TAN, tfu_pkg::ACT_COT, tfu_pkg::ACT_SEC, tfu_pkg::ACT_CSC: begin
				dm   = (act == tfu_pkg::ACT_TAN || act == tfu_pkg::ACT_SEC) ? cm : sm;
				dneg = (act == tfu_pkg::ACT_TAN || act == tfu_pkg::ACT_SEC) ? cneg : sneg;
				nm   = (act == tfu_pkg::ACT_TAN) ? sm :
					(act == tfu_pkg::ACT_COT) ? cm : ONE_Q;
				nneg = (act == tfu_pkg::ACT_TAN) ? sneg :
					(act == tfu_pkg::ACT_COT) ? cneg : 1'b0;
				pole = (dneg && dm != 0) ? (dm < pole_limit) : (dm <= pole_limit);
				if (pole) res.status = 1'b1;
				else res.value = saturate(divide_q(nm, dm), nneg != dneg);
			end
			default: ;
		endcase
		return res;
	endfunction

	// Send one transaction, idling about one cycle in four before it unless no_gaps is set
	task automatic send_trig(logic [2:0] act, logic [31:0] ang);
		while (!no_gaps && $urandom_range(99) < 26) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		in_item <= '{action: act, angle: ang};
		do @(posedge clk); while (busy);
		expected_q.push_back(trig_predict(act, ang));
	endtask

	// Hold until every expected result has arrived, then let the pipe settle
	task automatic drain_pipe();
		start <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_pole_limit(logic [31:0] v);
		drain_pipe();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pole_limit = v;
	endtask

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		tfu_pkg::out_t exp_r;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result value=%h status=%b", $time,
					out_item.value, out_item.status);
				error_count++;
			end else begin
				exp_r = expected_q.pop_front();
				if (exp_r.value !== out_item.value) begin
					$display("%0t: value expected %h actual %h", $time, exp_r.value,
						out_item.value);
					error_count++;
				end
				if (exp_r.status !== out_item.status) begin
					$display("%0t: status expected %b actual %b", $time, exp_r.status,
						out_item.status);
					error_count++;
				end
			end
		end
	end

	task automatic test_extremes();
		logic [31:0] angs[10];
		angs = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1, ANG_QTR_PI,
			ANG_HALF_PI, ANG_PI, ANG_TWO_PI, -ANG_HALF_PI};
		foreach (angs[i]) begin
			send_trig(tfu_pkg::ACT_SIN, angs[i]);
			send_trig(tfu_pkg::ACT_TAN, angs[i]);
		end
		send_trig(tfu_pkg::ACT_COS, ANG_PI);
		send_trig(tfu_pkg::ACT_COT, 32'h0);
		send_trig(tfu_pkg::ACT_SEC, ANG_HALF_PI);
		send_trig(tfu_pkg::ACT_CSC, ANG_PI);
		send_trig(ACT_SPARE6, ANG_QTR_PI);
		send_trig(ACT_SPARE7, 32'hFFFF_FFFF);
	endtask

	task automatic test_poles(logic [31:0] lim);
		write_pole_limit(lim);
		for (int k = 0; k < 12; k++)
			send_trig(3'(tfu_pkg::ACT_TAN + k % 4),
				(k % 2) ? ANG_HALF_PI + k - 6 : ANG_PI + k - 6);
	endtask

	task automatic test_random(int count);
		logic [31:0] ang;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(3))
				0: ang = $urandom;
				1: ang = $urandom_range(0, 8) * ANG_QTR_PI + $urandom_range(0, 64) - 32;
				2: ang = -($urandom_range(0, 8) * ANG_HALF_PI) + $urandom_range(0, 8) - 4;
				default: ang = $urandom_range(0, 2 * ANG_TWO_PI) - ANG_TWO_PI;
			endcase
			send_trig(3'($urandom_range(7)), ang);
			// pause once for the pipe to empty
			if (k == count / 2) drain_pipe();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_poles(32'd0);
		test_poles(32'hFFFF_FFFF);
		test_poles(32'd1 << 20);
		write_pole_limit(32'd4295);
		test_random(300);
		no_gaps = 1'b1;
		test_random(200);
		no_gaps = 1'b0;
		write_pole_limit($urandom);
		test_random(350);
		drain_pipe();
		repeat (150) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end
endmodule
